/* rtl/core/bfm_pkg.sv */
// bfm_pkg: shared types and constants of the box filter mean core
// used by bfm_ctrl, bfm_datapath and box_filter_mean_core; no dependencies
package bfm_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int KSIZE_W  = 4;
    localparam int DIM_W    = 11;
    localparam int SUM_W    = 16;
    localparam int HALF_W   = 3;
    localparam int DIV_CNT_W = 4;

    // register reset values
    localparam logic [KSIZE_W-1:0] KERNEL_RESET = 4'd15;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd1024;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd1024;

    // register indexes
    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic start_sum;
        logic start_div;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic produce;
        logic inner;
        logic sum_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/box_filter_mean_core.sv */
// box_filter_mean_core: top level of the streaming box mean filter
// depends on bfm_pkg, bfm_ctrl and bfm_datapath
//
// Usage: raster samples enter on the s_ channel, one beat per pixel with
// s_tuser low; a beat with s_tuser high is a drain step. Results leave on
// the m_ channel: m_tdata is the mean, m_tuser flags a border pixel that
// repeats the last interior mean, m_tlast marks the frame's last pixel.
// A result belongs to the pixel p*W+p beats back (p = kernel_size/2);
// after the frame is in, one drain beat flushes one pending result.
// A beat that gives no result is only taken; a border result goes through
// the take and the emit; an interior result goes through the take, the
// one-read-per-cycle window walk over the row store, the read latency and
// handoff, the bit-serial divider by k*k, and the emit. A finished result
// waits in the output register while the next beat is taken; if m_tready
// stays low the block stalls in its emit step until the register frees.
// Reset (aresetn low, synchronous) restores kernel 15, 1024x1024 and starts
// a fresh frame; the row store is not cleared. A write to the kernel, width
// or height register over the APB port restarts the frame.
module box_filter_mean_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tuser,   // [0] op
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] mean_value
    output logic        m_tuser,   // [0] border
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bfm_pkg::KSIZE_W-1:0] kernel_reg;
    logic [bfm_pkg::DIM_W-1:0]   width_reg;
    logic [bfm_pkg::DIM_W-1:0]   height_reg;
    logic                        wr_en, restart;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign restart = wr_en && ((reg_idx == bfm_pkg::REG_KERNEL)
                     || (reg_idx == bfm_pkg::REG_WIDTH) || (reg_idx == bfm_pkg::REG_HEIGHT));

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= bfm_pkg::KERNEL_RESET;
            width_reg  <= bfm_pkg::WIDTH_RESET;
            height_reg <= bfm_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            if (reg_idx == bfm_pkg::REG_KERNEL) kernel_reg <= pwdata[bfm_pkg::KSIZE_W-1:0];
            if (reg_idx == bfm_pkg::REG_WIDTH)  width_reg  <= pwdata[bfm_pkg::DIM_W-1:0];
            if (reg_idx == bfm_pkg::REG_HEIGHT) height_reg <= pwdata[bfm_pkg::DIM_W-1:0];
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        if (reg_idx == bfm_pkg::REG_KERNEL) prdata = 32'(kernel_reg);
        else if (reg_idx == bfm_pkg::REG_WIDTH) prdata = 32'(width_reg);
        else if (reg_idx == bfm_pkg::REG_HEIGHT) prdata = 32'(height_reg);
    end

    bfm_pkg::cmd_t cmd;
    bfm_pkg::sts_t sts;

    bfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_kernel  (kernel_reg),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .cfg_restart (restart),
        .in_op       (s_tuser),
        .in_sample   (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* rtl/core/bfm_ctrl.sv */
// bfm_ctrl: sequencer of the box filter mean core
// depends on bfm_pkg; drives the datapath through cmd_t, watches sts_t
module bfm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bfm_pkg::sts_t   sts,
    output bfm_pkg::cmd_t   cmd
);

    bfm_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfm_pkg::ST_IDLE: begin
                if (in_valid && sts.produce) begin
                    state_next = sts.inner ? bfm_pkg::ST_SUM : bfm_pkg::ST_EMIT;
                end
            end
            bfm_pkg::ST_SUM: begin
                if (sts.sum_done) state_next = bfm_pkg::ST_DIV;
            end
            bfm_pkg::ST_DIV: begin
                if (sts.div_done) state_next = bfm_pkg::ST_EMIT;
            end
            bfm_pkg::ST_EMIT: begin
                if (sts.out_free) state_next = bfm_pkg::ST_IDLE;
            end
            default: state_next = bfm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bfm_pkg::ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.take      = in_valid;
                cmd.start_sum = in_valid && sts.produce && sts.inner;
            end
            bfm_pkg::ST_SUM: begin
                cmd.start_div = sts.sum_done;
            end
            bfm_pkg::ST_DIV: begin
            end
            bfm_pkg::ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/bfm_datapath.sv */
// bfm_datapath: row store, frame counters, window summer, divider, output register
// depends on bfm_pkg; commanded by bfm_ctrl
module bfm_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bfm_pkg::cmd_t                 cmd,
    output bfm_pkg::sts_t                 sts,
    input  logic [bfm_pkg::KSIZE_W-1:0]   cfg_kernel,
    input  logic [bfm_pkg::DIM_W-1:0]     cfg_width,
    input  logic [bfm_pkg::DIM_W-1:0]     cfg_height,
    input  logic                          cfg_restart,
    input  logic                          in_op,
    input  logic [bfm_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfm_pkg::SAMPLE_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int STORE_ROWS = 2 * (MAX_KERNEL / 2) + 1;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int H_W        = $clog2(MAX_HEIGHT + 1);
    localparam int IDX_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int DEPTH      = 2 ** ADDR_W;
    localparam int SW         = bfm_pkg::SAMPLE_W;

    // clamped frame geometry
    logic [bfm_pkg::KSIZE_W-1:0] k_eff;
    logic [W_W-1:0]              w_eff;
    logic [H_W-1:0]              h_eff;
    logic [bfm_pkg::HALF_W-1:0]  p;
    logic [IDX_W-1:0]            total, lag, p_idx;
    logic [SW-1:0]               divisor;

    always_comb begin
        if (cfg_kernel == '0) k_eff = bfm_pkg::KSIZE_W'(1);
        else if (32'(cfg_kernel) > MAX_KERNEL) k_eff = bfm_pkg::KSIZE_W'(MAX_KERNEL);
        else k_eff = cfg_kernel;
        if (cfg_width == '0) w_eff = W_W'(1);
        else if (32'(cfg_width) > MAX_WIDTH) w_eff = W_W'(MAX_WIDTH);
        else w_eff = W_W'(cfg_width);
        if (cfg_height == '0) h_eff = H_W'(1);
        else if (32'(cfg_height) > MAX_HEIGHT) h_eff = H_W'(MAX_HEIGHT);
        else h_eff = H_W'(cfg_height);
    end

    assign p       = bfm_pkg::HALF_W'(k_eff >> 1);
    assign p_idx   = IDX_W'(p);
    assign total   = IDX_W'(w_eff) * IDX_W'(h_eff);
    assign lag     = p_idx * IDX_W'(w_eff) + p_idx;
    assign divisor = SW'(k_eff) * SW'(k_eff);

    // frame counters
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [IDX_W-1:0]  have_reg, have_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [SW-1:0]     recent_reg, recent_next;

    logic pixel_ok, drain_ok, write_en, last_out, inner;
    logic [SW-1:0] mean_sat;

    assign pixel_ok = (in_op == bfm_pkg::OP_PIXEL) && (have_reg < total)
                      && ((have_reg + IDX_W'(1)) > lag) && (out_idx_reg < total);
    assign drain_ok = (in_op == bfm_pkg::OP_DRAIN) && (have_reg == total)
                      && (out_idx_reg < total);
    assign write_en = cmd.take && (in_op == bfm_pkg::OP_PIXEL) && (have_reg < total);
    assign last_out = (out_idx_reg + IDX_W'(1)) >= total;

    // interior test of the pending output pixel
    assign inner = (IDX_W'(out_row_reg) >= p_idx)
                   && ((IDX_W'(out_row_reg) + p_idx) < IDX_W'(h_eff))
                   && (IDX_W'(out_col_reg) >= p_idx)
                   && ((IDX_W'(out_col_reg) + p_idx) < IDX_W'(w_eff));

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        have_next     = have_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        out_idx_next  = out_idx_reg;
        recent_next   = recent_reg;
        // input side advance
        if (write_en) begin
            have_next = have_reg + IDX_W'(1);
            if ((W_W'(in_col_reg) + W_W'(1)) == w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
                in_slot_next = (in_slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                               : in_slot_reg + SLOT_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
        // output side advance
        if (cmd.emit) begin
            if (inner) recent_next = mean_sat;
            if ((W_W'(out_col_reg) + W_W'(1)) == w_eff) begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
                out_slot_next = (out_slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                : out_slot_reg + SLOT_W'(1);
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
            out_idx_next = out_idx_reg + IDX_W'(1);
        end
        // frame restart
        if (cfg_restart || (cmd.emit && last_out)) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            have_next     = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            out_idx_next  = '0;
            recent_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            have_reg     <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_idx_reg  <= '0;
            recent_reg   <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            have_reg     <= have_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            out_idx_reg  <= out_idx_next;
            recent_reg   <= recent_next;
        end
    end

    // window walk: one row store read per cycle
    logic [SLOT_W-1:0]           win_slot_reg, win_slot_next;
    logic [COL_W-1:0]            win_col0_reg, win_col0_next;
    logic [bfm_pkg::KSIZE_W-1:0] col_cnt_reg, col_cnt_next;
    logic [bfm_pkg::KSIZE_W-1:0] row_cnt_reg, row_cnt_next;
    logic                        issue_reg, issue_next;
    logic                        rd_valid_reg;
    logic [SW-1:0]               rd_data_reg;
    logic [bfm_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [SLOT_W:0]             slot_wrap;
    logic [bfm_pkg::KSIZE_W-1:0] span;
    logic [ADDR_W-1:0]           rd_addr, wr_addr;

    assign span      = bfm_pkg::KSIZE_W'({p, 1'b0});
    assign slot_wrap = {1'b0, out_slot_reg} + (SLOT_W + 1)'(STORE_ROWS) - (SLOT_W + 1)'(p);
    assign rd_addr   = {win_slot_reg, win_col0_reg + COL_W'(col_cnt_reg)};
    assign wr_addr   = {in_slot_reg, in_col_reg};

    always_comb begin
        win_slot_next = win_slot_reg;
        win_col0_next = win_col0_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        issue_next    = issue_reg;
        acc_next      = acc_reg;
        if (rd_valid_reg) acc_next = acc_reg + bfm_pkg::SUM_W'(rd_data_reg);
        if (cmd.start_sum) begin
            win_slot_next = (slot_wrap >= (SLOT_W + 1)'(STORE_ROWS))
                            ? SLOT_W'(slot_wrap - (SLOT_W + 1)'(STORE_ROWS))
                            : SLOT_W'(slot_wrap);
            win_col0_next = out_col_reg - COL_W'(p);
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            issue_next    = 1'b1;
            acc_next      = '0;
        end else if (issue_reg) begin
            if (col_cnt_reg == span) begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + bfm_pkg::KSIZE_W'(1);
                win_slot_next = (win_slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                : win_slot_reg + SLOT_W'(1);
                if (row_cnt_reg == span) issue_next = 1'b0;
            end else begin
                col_cnt_next = col_cnt_reg + bfm_pkg::KSIZE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            issue_reg    <= issue_next;
            rd_valid_reg <= issue_reg;
        end
    end

    always_ff @(posedge aclk) begin
        win_slot_reg <= win_slot_next;
        win_col0_reg <= win_col0_next;
        col_cnt_reg  <= col_cnt_next;
        row_cnt_reg  <= row_cnt_next;
        acc_reg      <= acc_next;
    end

    // row store memory
    logic [SW-1:0] row_store_mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (write_en) row_store_mem[wr_addr] <= in_sample;
        if (issue_reg) rd_data_reg <= row_store_mem[rd_addr];
    end

    // restoring divider, one quotient bit per cycle
    logic [bfm_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [SW-1:0]               rem_reg, rem_next;
    logic [bfm_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                        div_busy_reg, div_busy_next;
    logic [SW:0]                 rem_sh;

    assign rem_sh = {rem_reg, quo_reg[bfm_pkg::SUM_W-1]};

    always_comb begin
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;
        if (cmd.start_div) begin
            quo_next      = acc_reg;
            rem_next      = '0;
            div_cnt_next  = '0;
            div_busy_next = 1'b1;
        end else if (div_busy_reg) begin
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = SW'(rem_sh - {1'b0, divisor});
                quo_next = {quo_reg[bfm_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = SW'(rem_sh);
                quo_next = {quo_reg[bfm_pkg::SUM_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + bfm_pkg::DIV_CNT_W'(1);
            if (div_cnt_reg == '1) div_busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else begin
            div_busy_reg <= div_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
    end

    // saturate the quotient to a sample
    assign mean_sat = (quo_reg > bfm_pkg::SUM_W'(255)) ? 8'hFF : SW'(quo_reg);

    // output register
    logic          out_valid_reg;
    logic [SW-1:0] out_mean_reg;
    logic          out_border_reg, out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_mean_reg   <= inner ? mean_sat : recent_reg;
            out_border_reg <= !inner;
            out_last_reg   <= (out_idx_reg + IDX_W'(1)) == total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mean_reg;
    assign m_tuser  = out_border_reg;
    assign m_tlast  = out_last_reg;

    // status to the controller
    assign sts.produce  = pixel_ok || drain_ok;
    assign sts.inner    = inner;
    assign sts.sum_done = !issue_reg && !rd_valid_reg && !cmd.start_sum;
    assign sts.div_done = !div_busy_reg && !cmd.start_div;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule
